### hw/rtl/cdt_pkg.sv
// Package for the coherence diffusion tensor block: transaction types, register
// indexes, pipeline depths and constant helper functions. No dependencies.
package cdt_pkg;

   typedef struct packed {
      logic [30:0]        tensor_xx;
      logic signed [31:0] tensor_xy;
      logic [30:0]        tensor_yy;
   } req_type;

   typedef struct packed {
      logic [15:0]        diff_xx;
      logic signed [15:0] diff_xy;
      logic [15:0]        diff_yy;
   } rsp_type;

   localparam logic [1:0] REG_ALPHA    = 2'd0;
   localparam logic [1:0] REG_CONTRAST = 2'd1;
   localparam logic [1:0] REG_EXPONENT = 2'd2;

   localparam logic [15:0] ALPHA_RESET    = 16'd66;
   localparam logic [47:0] CONTRAST_RESET = 48'd0;
   localparam logic [7:0]  EXPONENT_RESET = 8'd16;

   localparam int SQRT_STEPS = 32;
   localparam int LOG_STEPS  = 24;
   localparam int POW_STEPS  = 24;
   localparam int DIV_STEPS  = 16;

   localparam logic [26:0] LOG2E_Q26 = 27'd96817625;

   localparam logic [1:0] CT_ZERO  = 2'd0;
   localparam logic [1:0] CT_SHIFT = 2'd1;
   localparam logic [1:0] CT_POW   = 2'd2;

   function automatic logic [63:0] isqrt_const(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = 64'd0;
      x = n;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Factor 2^(2^-k) in Q1.30, built by repeated truncating square roots.
   function automatic logic [31:0] pow2_factor(input int k);
      logic [63:0] t;
      t = 64'd2 << 30;
      for (int j = 0; j < k; j++) begin
         t = isqrt_const(t << 30);
      end
      return t[31:0];
   endfunction

   function automatic logic [5:0] lead_one(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

   function automatic logic [30:0] norm_q30(input logic [63:0] v, input logic [5:0] n);
      logic [63:0] z;
      if (n >= 6'd30) begin
         z = v >> (n - 6'd30);
      end else begin
         z = v << (6'd30 - n);
      end
      return z[30:0];
   endfunction

endpackage

### hw/rtl/coherence_diffusion_tensor.sv
// Coherence-enhancing diffusion tensor pipeline, one pixel per clock.
// Depends on cdt_pkg for transaction types, constants and helper functions.
//
// Usage: a transaction on the request side is taken on any clock edge with start
// high; busy is always low, so a new structure tensor can enter every cycle.
// Each transaction yields exactly one result, shown on rsp_data for one cycle
// with rsp_valid high. The pipeline depth is set by the 32-step square root,
// the 24-step logarithm, the two 24-step power-of-two multiplier chains and
// the 16-step restoring dividers.
// Throughput is one transaction per cycle at any input pattern.
// The receiver cannot stall; results are always delivered in order.
// Registers are reached through the APB port at byte addresses 0, 8 and 16
// and must be written only while no transaction is in flight.
// Synchronous reset empties the pipeline and restores the register defaults.
module coherence_diffusion_tensor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdt_pkg::req_type  req_data,
   output logic              rsp_valid,
   output cdt_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);
   import cdt_pkg::*;

   localparam int W_G   = LOG_STEPS + 2 * POW_STEPS + 6;
   localparam int W_N   = W_G + 2;
   localparam int LAT   = 7 + SQRT_STEPS + W_N + DIV_STEPS;

   typedef struct packed {
      logic [30:0] xx;
      logic [30:0] yy;
      logic [31:0] axy;
      logic        pneg;
      logic [1:0]  a2lo;
   } front_type;

   typedef struct packed {
      logic [61:0] a2;
      logic [63:0] axy2;
      front_type   fr;
   } r1_type;

   typedef struct packed {
      logic [63:0] s4;
      logic [34:0] rem;
      logic [31:0] root;
      front_type   fr;
   } sq_type;

   typedef struct packed {
      logic [32:0] d;
      front_type   fr;
   } dd_type;

   typedef struct packed {
      logic [22:0] p;
      logic [22:0] q;
      logic        turned;
      logic        pneg;
      logic        dzero;
   } carry_type;

   typedef struct packed {
      logic [5:0]  nd;
      logic [30:0] zd;
      logic [23:0] fd;
      logic [5:0]  nc;
      logic [30:0] zc;
      logic [23:0] fc;
   } lg_type;

   typedef struct packed {
      logic [1:0]        ctrl;
      logic signed [6:0] sh;
      logic [5:0]        k;
      logic [23:0]       f;
      logic [31:0]       r;
   } pw_type;

   typedef struct packed {
      logic [1:0]  ctrl;
      logic [36:0] x;
   } x_type;

   typedef struct packed {
      logic [1:0]  ctrl;
      logic [37:0] y;
   } y_type;

   typedef struct packed {
      logic [45:0] pp;
      logic [45:0] qq;
      logic [45:0] pq;
      logic [16:0] lam;
      logic        turned;
      logic        pneg;
   } a_type;

   typedef struct packed {
      logic [46:0] m;
      logic [63:0] t1;
      logic [63:0] t2;
      logic [63:0] t3;
      logic [63:0] t4;
      logic [63:0] t5;
      logic        xyneg;
   } b_type;

   typedef struct packed {
      logic [63:0] nx;
      logic [63:0] ny;
      logic [63:0] nxy;
      logic [47:0] den;
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qxy;
      logic        xyneg;
      logic        mzero;
   } dv_type;

   // Configuration registers.
   logic [15:0] alpha_ff, alpha_in;
   logic [47:0] contrast_ff, contrast_in;
   logic [7:0]  expo_ff, expo_in;
   logic        csr_write;

   always_comb begin
      csr_write   = psel & penable & pwrite & pready;
      alpha_in    = alpha_ff;
      contrast_in = contrast_ff;
      expo_in     = expo_ff;
      if (csr_write) begin
         case (paddr[4:3])
            REG_ALPHA:    alpha_in    = pwdata[15:0];
            REG_CONTRAST: contrast_in = pwdata[47:0];
            REG_EXPONENT: expo_in     = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:3])
         REG_ALPHA:    prdata = {48'd0, alpha_ff};
         REG_CONTRAST: prdata = {16'd0, contrast_ff};
         REG_EXPONENT: prdata = {56'd0, expo_ff};
         default:      prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_RESET;
         contrast_ff <= CONTRAST_RESET;
         expo_ff     <= EXPONENT_RESET;
      end else begin
         alpha_ff    <= alpha_in;
         contrast_ff <= contrast_in;
         expo_ff     <= expo_in;
      end
   end

   assign pready = 1'b1;
   assign busy   = 1'b0;

   // Valid bits travel beside the data.
   logic v_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start & ~busy;
         for (int i = 1; i < LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // Squares of the diagonal difference and of the off-diagonal term.
   r1_type      r1_ff, r1_in;
   logic [31:0] xyu;
   logic [30:0] adiff;

   always_comb begin
      xyu           = req_data.tensor_xy;
      adiff         = (req_data.tensor_xx >= req_data.tensor_yy) ?
                      req_data.tensor_xx - req_data.tensor_yy :
                      req_data.tensor_yy - req_data.tensor_xx;
      r1_in.fr.xx   = req_data.tensor_xx;
      r1_in.fr.yy   = req_data.tensor_yy;
      r1_in.fr.pneg = xyu[31];
      r1_in.fr.axy  = xyu[31] ? 32'd0 - xyu : xyu;
      r1_in.fr.a2lo = 2'b00;
      r1_in.a2      = {31'd0, adiff} * {31'd0, adiff};
      r1_in.axy2    = {32'd0, r1_in.fr.axy} * {32'd0, r1_in.fr.axy};
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
   end

   // Square root, two radicand bits per stage.
   sq_type sq_ff [0:SQRT_STEPS];
   sq_type sq_in [0:SQRT_STEPS];

   always_comb begin
      sq_in[0].s4      = r1_ff.axy2 + {2'b00, r1_ff.a2[61:2]};
      sq_in[0].rem     = 35'd0;
      sq_in[0].root    = 32'd0;
      sq_in[0].fr      = r1_ff.fr;
      sq_in[0].fr.a2lo = r1_ff.a2[1:0];
   end

   for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
      logic [34:0] rem_n;
      logic [34:0] test;
      always_comb begin
         rem_n       = {sq_ff[j-1].rem[32:0], sq_ff[j-1].s4[63:62]};
         test        = {1'b0, sq_ff[j-1].root, 2'b01};
         sq_in[j]    = sq_ff[j-1];
         sq_in[j].s4 = {sq_ff[j-1].s4[61:0], 2'b00};
         if (rem_n >= test) begin
            sq_in[j].rem  = rem_n - test;
            sq_in[j].root = {sq_ff[j-1].root[30:0], 1'b1};
         end else begin
            sq_in[j].rem  = rem_n;
            sq_in[j].root = {sq_ff[j-1].root[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= SQRT_STEPS; i++) begin
         sq_ff[i] <= sq_in[i];
      end
   end

   // Eigenvalue difference.
   dd_type      dd_ff, dd_in;
   logic [36:0] dd_lhs;
   logic [36:0] dd_rhs;

   always_comb begin
      dd_lhs   = {sq_ff[SQRT_STEPS].rem, 2'b00} + {35'd0, sq_ff[SQRT_STEPS].fr.a2lo};
      dd_rhs   = {3'd0, sq_ff[SQRT_STEPS].root, 2'b01};
      dd_in.d  = {sq_ff[SQRT_STEPS].root, 1'b0} + {32'd0, (dd_lhs >= dd_rhs)};
      dd_in.fr = sq_ff[SQRT_STEPS].fr;
   end

   always_ff @(posedge clock) begin
      dd_ff <= dd_in;
   end

   // Eigenvector scaling, carried beside the weight pipeline.
   carry_type   c_ff [0:W_N-1];
   carry_type   c_in0;
   logic [34:0] ev_ap;
   logic [34:0] ev_q;
   logic [34:0] ev_or;
   logic [34:0] ev_ps;
   logic [34:0] ev_qs;
   logic [3:0]  ev_sh;

   always_comb begin
      ev_ap = {2'b00, dd_ff.fr.axy, 1'b0};
      ev_q  = {4'd0, dd_ff.fr.yy} - {4'd0, dd_ff.fr.xx} + {2'b00, dd_ff.d};
      ev_or = ev_ap | ev_q;
      ev_sh = 4'd0;
      for (int s = 12; s >= 0; s--) begin
         if ((ev_or >> s) < 35'd8388608) begin
            ev_sh = 4'(s);
         end
      end
      ev_ps        = ev_ap >> ev_sh;
      ev_qs        = ev_q >> ev_sh;
      c_in0.p      = ev_ps[22:0];
      c_in0.q      = ev_qs[22:0];
      c_in0.turned = ((dd_ff.fr.xx | dd_ff.fr.yy) != 31'd0) && (dd_ff.d != 33'd0);
      c_in0.pneg   = dd_ff.fr.pneg;
      c_in0.dzero  = (dd_ff.d == 33'd0);
   end

   always_ff @(posedge clock) begin
      c_ff[0] <= c_in0;
      for (int i = 1; i < W_N; i++) begin
         c_ff[i] <= c_ff[i-1];
      end
   end

   // Logarithms of the difference and of the contrast constant.
   lg_type lg_ff [0:LOG_STEPS];
   lg_type lg_in [0:LOG_STEPS];

   always_comb begin
      lg_in[0].nd = lead_one({31'd0, dd_ff.d});
      lg_in[0].zd = norm_q30({31'd0, dd_ff.d}, lg_in[0].nd);
      lg_in[0].fd = 24'd0;
      lg_in[0].nc = lead_one({16'd0, contrast_ff});
      lg_in[0].zc = norm_q30({16'd0, contrast_ff}, lg_in[0].nc);
      lg_in[0].fc = 24'd0;
   end

   for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_log
      logic [61:0] pd;
      logic [61:0] pc;
      always_comb begin
         pd          = {31'd0, lg_ff[j-1].zd} * {31'd0, lg_ff[j-1].zd};
         pc          = {31'd0, lg_ff[j-1].zc} * {31'd0, lg_ff[j-1].zc};
         lg_in[j]    = lg_ff[j-1];
         lg_in[j].zd = pd[61] ? pd[61:31] : pd[60:30];
         lg_in[j].fd = {lg_ff[j-1].fd[22:0], pd[61]};
         lg_in[j].zc = pc[61] ? pc[61:31] : pc[60:30];
         lg_in[j].fc = {lg_ff[j-1].fc[22:0], pc[61]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= LOG_STEPS; i++) begin
         lg_ff[i] <= lg_in[i];
      end
   end

   // Exponent of two for the ratio.
   logic signed [43:0] l8_ff, l8_in;
   logic signed [43:0] lc;
   logic signed [43:0] ld;

   always_comb begin
      lc    = $signed({14'd0, lg_ff[LOG_STEPS].nc, lg_ff[LOG_STEPS].fc}) - 44'sd536870912;
      ld    = $signed({14'd0, lg_ff[LOG_STEPS].nd, lg_ff[LOG_STEPS].fd}) - 44'sd268435456;
      l8_in = (lc <<< 3) - $signed({36'd0, expo_ff}) * ld;
   end

   always_ff @(posedge clock) begin
      l8_ff <= l8_in;
   end

   // First power of two: the ratio x.
   pw_type      p1_ff [0:POW_STEPS];
   pw_type      p1_in [0:POW_STEPS];
   logic [43:0] off;

   always_comb begin
      off         = l8_ff + 44'sd5368709120;
      p1_in[0].k  = 6'd0;
      p1_in[0].f  = off[26:3];
      p1_in[0].r  = 32'h4000_0000;
      p1_in[0].sh = $signed({1'b0, off[32:27]}) - 7'sd38;
      if (contrast_ff == 48'd0 || l8_ff < -44'sd5368709120) begin
         p1_in[0].ctrl = CT_SHIFT;
      end else if (l8_ff >= 44'sd536870912) begin
         p1_in[0].ctrl = CT_ZERO;
      end else begin
         p1_in[0].ctrl = CT_POW;
      end
   end

   for (genvar j = 1; j <= POW_STEPS; j++) begin : g_pow1
      localparam logic [31:0] FACT = pow2_factor(j);
      logic [63:0] prod;
      always_comb begin
         prod     = {32'd0, p1_ff[j-1].r} * {32'd0, FACT};
         p1_in[j] = p1_ff[j-1];
         if (p1_ff[j-1].f[POW_STEPS-j]) begin
            p1_in[j].r = prod[61:30];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= POW_STEPS; i++) begin
         p1_ff[i] <= p1_in[i];
      end
   end

   // Scale by the integer exponent, then by log2(e).
   x_type       x_ff, x_in;
   y_type       y_ff, y_in;
   logic [36:0] x_ext;
   logic [6:0]  x_nsh;
   logic [63:0] y_prod;

   always_comb begin
      x_ext   = {5'd0, p1_ff[POW_STEPS].r};
      x_nsh   = 7'd0 - p1_ff[POW_STEPS].sh;
      x_in.ctrl = p1_ff[POW_STEPS].ctrl;
      if (!p1_ff[POW_STEPS].sh[6]) begin
         x_in.x = x_ext << p1_ff[POW_STEPS].sh[5:0];
      end else begin
         x_in.x = x_ext >> x_nsh[5:0];
      end
      y_prod    = {27'd0, x_ff.x} * {37'd0, LOG2E_Q26};
      y_in.ctrl = x_ff.ctrl;
      y_in.y    = y_prod[63:26];
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   // Second power of two: the weight g = 2^-y.
   pw_type      p2_ff [0:POW_STEPS];
   pw_type      p2_in [0:POW_STEPS];
   logic [32:0] fr_cmp;

   always_comb begin
      fr_cmp      = 33'h1_0000_0000 - {1'b0, y_ff.y[31:0]};
      p2_in[0].sh = 7'sd0;
      p2_in[0].r  = 32'h4000_0000;
      p2_in[0].f  = fr_cmp[31:8];
      p2_in[0].k  = y_ff.y[37:32];
      if (y_ff.ctrl != CT_POW) begin
         p2_in[0].ctrl = y_ff.ctrl;
         p2_in[0].k    = 6'd0;
      end else if (y_ff.y[37:32] >= 6'd40) begin
         p2_in[0].ctrl = CT_ZERO;
      end else if (y_ff.y[31:0] == 32'd0) begin
         p2_in[0].ctrl = CT_SHIFT;
      end else begin
         p2_in[0].ctrl = CT_POW;
      end
   end

   for (genvar j = 1; j <= POW_STEPS; j++) begin : g_pow2
      localparam logic [31:0] FACT = pow2_factor(j);
      logic [63:0] prod;
      always_comb begin
         prod     = {32'd0, p2_ff[j-1].r} * {32'd0, FACT};
         p2_in[j] = p2_ff[j-1];
         if (p2_ff[j-1].f[POW_STEPS-j]) begin
            p2_in[j].r = prod[61:30];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= POW_STEPS; i++) begin
         p2_ff[i] <= p2_in[i];
      end
   end

   // Weight and coherence eigenvalue.
   logic [16:0] g_ff, g_in;
   logic [16:0] lam_ff, lam_in;
   logic [6:0]  g_sh;
   logic [31:0] g_pow;
   logic [16:0] g_shift;
   logic [33:0] lam_prod;

   always_comb begin
      g_sh    = {1'b0, p2_ff[POW_STEPS].k} + 7'd15;
      g_pow   = p2_ff[POW_STEPS].r >> g_sh;
      g_shift = 17'h10000 >> p2_ff[POW_STEPS].k;
      case (p2_ff[POW_STEPS].ctrl)
         CT_ZERO:  g_in = 17'd0;
         CT_SHIFT: g_in = g_shift;
         CT_POW:   g_in = g_pow[16:0];
         default:  g_in = 17'd0;
      endcase
      lam_prod = (17'h10000 - {1'b0, alpha_ff}) * g_ff;
      if (c_ff[W_G].dzero) begin
         lam_in = {1'b0, alpha_ff};
      end else begin
         lam_in = {1'b0, alpha_ff} + lam_prod[32:16];
      end
   end

   always_ff @(posedge clock) begin
      g_ff   <= g_in;
      lam_ff <= lam_in;
   end

   // Tensor numerators.
   a_type       a_ff, a_in;
   b_type       b_ff, b_in;
   logic [45:0] sx;
   logic [45:0] sy;
   logic [16:0] lam_d;

   always_comb begin
      a_in.pp     = {23'd0, c_ff[W_N-1].p} * {23'd0, c_ff[W_N-1].p};
      a_in.qq     = {23'd0, c_ff[W_N-1].q} * {23'd0, c_ff[W_N-1].q};
      a_in.pq     = {23'd0, c_ff[W_N-1].p} * {23'd0, c_ff[W_N-1].q};
      a_in.lam    = lam_ff;
      a_in.turned = c_ff[W_N-1].turned;
      a_in.pneg   = c_ff[W_N-1].pneg;

      sx         = a_ff.turned ? a_ff.qq : a_ff.pp;
      sy         = a_ff.turned ? a_ff.pp : a_ff.qq;
      lam_d      = a_ff.lam - {1'b0, alpha_ff};
      b_in.m     = {1'b0, a_ff.pp} + {1'b0, a_ff.qq};
      b_in.t1    = {47'd0, a_ff.lam} * {18'd0, sx};
      b_in.t2    = {48'd0, alpha_ff} * {18'd0, sy};
      b_in.t3    = {47'd0, a_ff.lam} * {18'd0, sy};
      b_in.t4    = {48'd0, alpha_ff} * {18'd0, sx};
      b_in.t5    = {47'd0, lam_d} * {18'd0, a_ff.pq};
      b_in.xyneg = a_ff.turned ? ~a_ff.pneg : a_ff.pneg;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   // Rounded division by 2m, one quotient bit per stage.
   dv_type dv_ff [0:DIV_STEPS];
   dv_type dv_in [0:DIV_STEPS];

   always_comb begin
      dv_in[0].nx    = b_ff.t1 + b_ff.t2 + {17'd0, b_ff.m};
      dv_in[0].ny    = b_ff.t3 + b_ff.t4 + {17'd0, b_ff.m};
      dv_in[0].nxy   = b_ff.t5 + {17'd0, b_ff.m};
      dv_in[0].den   = {b_ff.m, 1'b0};
      dv_in[0].qx    = 16'd0;
      dv_in[0].qy    = 16'd0;
      dv_in[0].qxy   = 16'd0;
      dv_in[0].xyneg = b_ff.xyneg;
      dv_in[0].mzero = (b_ff.m == 47'd0);
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      localparam int SH = DIV_STEPS - j;
      logic [63:0] sd;
      always_comb begin
         sd       = {16'd0, dv_ff[j-1].den} << SH;
         dv_in[j] = dv_ff[j-1];
         if (dv_ff[j-1].nx >= sd) begin
            dv_in[j].nx     = dv_ff[j-1].nx - sd;
            dv_in[j].qx[SH] = 1'b1;
         end
         if (dv_ff[j-1].ny >= sd) begin
            dv_in[j].ny     = dv_ff[j-1].ny - sd;
            dv_in[j].qy[SH] = 1'b1;
         end
         if (dv_ff[j-1].nxy >= sd) begin
            dv_in[j].nxy     = dv_ff[j-1].nxy - sd;
            dv_in[j].qxy[SH] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
         dv_ff[i] <= dv_in[i];
      end
   end

   // Result register.
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      if (dv_ff[DIV_STEPS].mzero) begin
         rsp_in.diff_xx = 16'd0;
         rsp_in.diff_xy = 16'sd0;
         rsp_in.diff_yy = 16'd0;
      end else begin
         rsp_in.diff_xx = dv_ff[DIV_STEPS].qx;
         rsp_in.diff_yy = dv_ff[DIV_STEPS].qy;
         rsp_in.diff_xy = dv_ff[DIV_STEPS].xyneg ? 16'd0 - dv_ff[DIV_STEPS].qxy :
                          dv_ff[DIV_STEPS].qxy;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = v_ff[LAT-1];
   assign rsp_data  = rsp_ff;

endmodule

### tb/cdt_checker.sv
`timescale 1ns / 100ps
// Checker for the coherence diffusion tensor block: watches the request, result and
// register ports, predicts each result and compares it. Depends on cdt_pkg.
module cdt_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  cdt_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  cdt_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output int                failures,
   output int                pending,
   output int                results_seen
);
   import cdt_pkg::*;

   localparam longint Q24_ONE = 64'd16777216;
   localparam longint L8_ONE  = 64'd134217728;

   logic [15:0] alpha_q16;
   logic [47:0] contrast_q32;
   logic [7:0]  exponent_q4;

   rsp_type expected_tensors[$];

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_q24(input longint unsigned v);
      int n;
      longint unsigned z;
      longint unsigned frac;
      n = 63;
      while (n > 0 && v[n] == 1'b0) n--;
      z = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         z = z * z;
         frac = frac << 1;
         if (z >= (64'd1 << 61)) begin
            frac = frac | 64'd1;
            z = z >> 31;
         end else begin
            z = z >> 30;
         end
      end
      return longint'(n) * Q24_ONE + longint'(frac);
   endfunction

   function automatic longint unsigned pow2_q30(input longint unsigned f);
      longint unsigned r;
      longint unsigned t;
      r = 64'd1 << 30;
      t = 64'd2 << 30;
      f = f & 64'hFF_FFFF;
      for (int k = 1; k <= 24; k++) begin
         t = int_sqrt(t << 30);
         if (f[24-k]) r = (r * t) >> 30;
      end
      return r;
   endfunction

   function automatic longint unsigned coherence_weight(input longint unsigned dq);
      longint lc;
      longint ld;
      longint l8;
      longint n;
      longint sh;
      longint unsigned off;
      longint unsigned x;
      longint unsigned y;
      longint unsigned k;
      longint unsigned fr;
      if (contrast_q32 == 0) return 65536;
      lc = log2_q24(contrast_q32) - 32 * Q24_ONE;
      ld = log2_q24(dq) - 16 * Q24_ONE;
      l8 = 8 * lc - longint'(exponent_q4) * ld;
      if (l8 >= 4 * L8_ONE) return 0;
      if (l8 < -40 * L8_ONE) return 65536;
      off = l8 + 40 * L8_ONE;
      n = longint'(off >> 27) - 40;
      x = pow2_q30((off & (L8_ONE - 1)) >> 3);
      sh = n + 2;
      if (sh >= 0) x = x << sh;
      else x = x >> (-sh);
      y = (x * 64'(LOG2E_Q26)) >> 26;
      k = y >> 32;
      fr = y & 64'hFFFF_FFFF;
      if (k >= 40) return 0;
      if (fr == 0) return 64'd65536 >> k;
      return pow2_q30(((64'd1 << 32) - fr) >> 8) >> (15 + k);
   endfunction

   function automatic rsp_type diffusion_tensor(input req_type t);
      longint unsigned xx, yy, axy, adiff, a2, s4, k, rem, d, ap, q;
      longint unsigned p_s, q_s, m, lam1, sx, sy, nxx, nyy, nxy, mxy, alpha;
      longint sxy, dif;
      bit pneg, turned, xyneg;
      int s;
      rsp_type r;
      xx = t.tensor_xx;
      yy = t.tensor_yy;
      sxy = t.tensor_xy;
      dif = longint'(xx) - longint'(yy);
      adiff = (dif < 0) ? -dif : dif;
      axy = (sxy < 0) ? -sxy : sxy;
      a2 = adiff * adiff;
      s4 = axy * axy + (a2 >> 2);
      k = int_sqrt(s4);
      rem = s4 - k * k;
      d = 2 * k + ((4 * rem + (a2 & 3) >= 4 * k + 1) ? 1 : 0);
      ap = 2 * axy;
      q = yy - xx + d;
      pneg = sxy < 0;
      turned = (xx + yy) > 0 && d > 0;
      alpha = alpha_q16;
      s = 0;
      while ((ap >> s) >= (64'd1 << 23) || (q >> s) >= (64'd1 << 23)) s++;
      p_s = ap >> s;
      q_s = q >> s;
      m = p_s * p_s + q_s * q_s;
      r = '0;
      if (m == 0) return r;
      lam1 = (d == 0) ? alpha : alpha + (((65536 - alpha) * coherence_weight(d)) >> 16);
      if (turned) begin
         sx = q_s * q_s;
         sy = p_s * p_s;
         xyneg = !pneg;
      end else begin
         sx = p_s * p_s;
         sy = q_s * q_s;
         xyneg = pneg;
      end
      nxx = lam1 * sx + alpha * sy;
      nyy = lam1 * sy + alpha * sx;
      nxy = (lam1 - alpha) * p_s * q_s;
      mxy = (nxy + m) / (2 * m);
      if (p_s == 0) mxy = 0;
      r.diff_xx = 16'((nxx + m) / (2 * m));
      r.diff_xy = 16'(xyneg ? (64'd0 - mxy) : mxy);
      r.diff_yy = 16'((nyy + m) / (2 * m));
      return r;
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         alpha_q16 = ALPHA_RESET;
         contrast_q32 = CONTRAST_RESET;
         exponent_q4 = EXPONENT_RESET;
         expected_tensors.delete();
         pending = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               REG_ALPHA: alpha_q16 = pwdata[15:0];
               REG_CONTRAST: contrast_q32 = pwdata[47:0];
               REG_EXPONENT: exponent_q4 = pwdata[7:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_tensors.push_back(diffusion_tensor(req_data));
         end
         if (rsp_valid) begin
            results_seen++;
            if (expected_tensors.size() == 0) begin
               failures++;
               $display("%0t: unexpected transaction xx=%0d xy=%0d yy=%0d", $time,
                        rsp_data.diff_xx, rsp_data.diff_xy, rsp_data.diff_yy);
            end else begin
               want = expected_tensors.pop_front();
               if (want.diff_xx !== rsp_data.diff_xx || want.diff_xy !== rsp_data.diff_xy
                   || want.diff_yy !== rsp_data.diff_yy) begin
                  failures++;
                  $display("%0t: mismatch expected xx=%0d xy=%0d yy=%0d, got xx=%0d xy=%0d yy=%0d",
                           $time, want.diff_xx, want.diff_xy, want.diff_yy,
                           rsp_data.diff_xx, rsp_data.diff_xy, rsp_data.diff_yy);
               end
            end
         end
         pending = expected_tensors.size();
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for coherence_diffusion_tensor: clock, reset, register writes
// and pixel stimulus in phases. Depends on cdt_pkg and cdt_checker.
module testbench;
   import cdt_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;
   int          failures;
   int          pending;
   int          results_seen;
   int          pixels_sent;

   coherence_diffusion_tensor i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cdt_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
      .failures(failures), .pending(pending), .results_seen(results_seen)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 200000);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic send_pixel(input req_type pixel, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= pixel;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   function automatic req_type random_pixel();
      req_type p;
      int shape;
      shape = $urandom_range(5);
      p.tensor_xx = 31'($urandom);
      p.tensor_xy = $urandom;
      p.tensor_yy = 31'($urandom);
      if (shape == 1) begin
         p.tensor_xx = p.tensor_xx >> $urandom_range(30);
         p.tensor_xy = p.tensor_xy >>> $urandom_range(31);
         p.tensor_yy = p.tensor_yy >> $urandom_range(30);
      end else if (shape == 2) begin
         p.tensor_yy = p.tensor_xx;
      end else if (shape == 3) begin
         p.tensor_xy = 32'sd0;
      end else if (shape == 4) begin
         p.tensor_xx = 31'($urandom_range(20));
         p.tensor_xy = 32'($urandom_range(40)) - 32'sd20;
         p.tensor_yy = 31'($urandom_range(20));
      end
      return p;
   endfunction

   task automatic run_directed(input int idle_pct);
      req_type corners[$];
      req_type p;
      logic [30:0] big;
      big = 31'h7FFF_FFFF;
      corners = '{
         '{31'd0, 32'sd0, 31'd0},
         '{31'd65536, 32'sd0, 31'd65536},
         '{31'd65536, 32'sd0, 31'd0},
         '{31'd0, 32'sd0, 31'd65536},
         '{big, 32'sd0, big},
         '{big, -32'sd2147483648, 31'd0},
         '{31'd0, 32'sd2147483647, big},
         '{big, 32'sd2147483647, big},
         '{big, -32'sd1, big},
         '{31'd0, -32'sd1, 31'd0},
         '{31'd1, 32'sd1, 31'd0},
         '{31'd0, 32'sd65536, 31'd0},
         '{31'd65536, -32'sd65536, 31'd65536},
         '{31'h5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA},
         '{31'h2AAA_AAAA, 32'sh5555_5555, 31'h5555_5555},
         '{31'd3, 32'sd0, 31'd7}
      };
      foreach (corners[i]) begin
         p = corners[i];
         send_pixel(p, idle_pct);
      end
   endtask

   initial begin
      int idle_pct[6] = '{0, 59, 0, 20, 59, 20};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      pixels_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: begin
                  write_reg(REG_ALPHA, 64'd0);
                  write_reg(REG_CONTRAST, 64'd1 << 32);
                  write_reg(REG_EXPONENT, 64'd16);
               end
               2: begin
                  write_reg(REG_ALPHA, 64'd65535);
                  write_reg(REG_CONTRAST, 64'hFFFF_FFFF_FFFF);
                  write_reg(REG_EXPONENT, 64'd255);
               end
               3: begin
                  write_reg(REG_ALPHA, 64'd30000);
                  write_reg(REG_CONTRAST, 64'd1);
                  write_reg(REG_EXPONENT, 64'd0);
               end
               default: begin
                  write_reg(REG_ALPHA, 64'($urandom_range(65535)));
                  write_reg(REG_CONTRAST, {16'd0, 48'($urandom) << $urandom_range(16)});
                  write_reg(REG_EXPONENT, 64'($urandom_range(1, 255)));
               end
            endcase
         end
         run_directed(idle_pct[phase]);
         repeat (60) send_pixel(random_pixel(), idle_pct[phase]);
      end
      @(negedge clock);
      start <= 1'b0;
      wait_idle();
      $display("Sent %0d pixels over 6 register settings, checked %0d results.",
               pixels_sent, results_seen);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
